// File: hw/rtl/scc_pkg.sv
// Shared constants, types and helper functions for the sector cache clock controller.
// Used by the tag RAM, the datapath, the controller, the top level and the checker.
// Depends on nothing else.
`default_nettype none

package scc_pkg;

	localparam int ENTRIES       = 64;
	localparam int SECTOR_BITS   = 32;
	localparam int SECTOR_PORT_W = 32;
	localparam int KIND_W        = 3;
	localparam int IDX_W         = $clog2(ENTRIES);
	localparam int LANES         = 8;
	localparam int LANE_W        = $clog2(LANES);
	localparam int ROWS          = ENTRIES / LANES;
	localparam int ROW_W         = $clog2(ROWS);

	typedef logic [IDX_W-1:0]       idx_t;
	typedef logic [ROW_W-1:0]       row_t;
	typedef logic [LANE_W-1:0]      lane_t;
	typedef logic [SECTOR_BITS-1:0] tag_t;
	typedef tag_t [LANES-1:0]       tag_row_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_READ    = 3'd0,
		KIND_WRITE   = 3'd1,
		KIND_ZERO    = 3'd2,
		KIND_RELEASE = 3'd3,
		KIND_FLUSH   = 3'd4
	} kind_t;

	// Source of the row address on the tag RAM read port.
	typedef enum logic [2:0] {
		RD_NONE = 3'd0,
		RD_SCAN = 3'd1,
		RD_SEL  = 3'd2,
		RD_REQ  = 3'd3,
		RD_FPTR = 3'd4
	} rd_sel_t;

	// Which result beat is loaded into the output register.
	typedef enum logic [1:0] {
		BEAT_LOOKUP    = 2'd0,
		BEAT_RELEASE   = 2'd1,
		BEAT_FLUSH_MID = 2'd2,
		BEAT_FLUSH_END = 2'd3
	} beat_t;

	typedef struct packed {
		logic    load;
		logic    scan_clr;
		logic    scan_en;
		rd_sel_t rd_sel;
		logic    sel_scan;
		logic    sel_hand;
		logic    hand_step;
		logic    push;
		beat_t   beat;
		logic    upd_lookup;
		logic    upd_release;
		logic    flush_take;
		logic    fptr_clr;
		logic    fptr_inc;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic hit;
		logic found;
		logic hand_acc;
		logic out_free;
		logic flush_sel;
		logic flush_end;
		logic pend_vld;
	} stat_t;

	typedef struct packed {
		logic hit;
		idx_t entry;
		logic fill;
		logic wb;
		tag_t wbsec;
		logic zero;
		logic last;
	} res_t;

	function automatic row_t row_of(idx_t e);
		return e[IDX_W-1:LANE_W];
	endfunction

	function automatic lane_t lane_of(idx_t e);
		return e[LANE_W-1:0];
	endfunction

	// Lowest set lane of a row vector; zero when none is set.
	function automatic lane_t first_lane(logic [LANES-1:0] v);
		lane_t r;
		r = '0;
		for (int i = LANES - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = lane_t'(i);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sector_cache_clock_controller_unit.sv
// Top level of the sector cache clock controller: controller and datapath.
// Depends on scc_pkg, scc_ctrl, scc_dpath (and through it scc_tag_ram).
//
//   channel | handshake          | payload
//   --------+--------------------+---------------------------------------------------
//   in      | in_valid/in_stall  | kind, sector, entry_index, keep_dirty
//   out     | out_valid/out_stall| hit, entry, fill_request, writeback_request,
//           |                    | writeback_sector, zero_data, last
//
// Read, write and zero fill run an eight-row tag scan through the registered tag RAM; a hit
// ends the scan at its row, a miss with a free entry then reads the victim's tag, and when
// none is free the hand first clears one accessed mark per step until it finds an unmarked one.
// Release reads the entry's tag before its beat; flush walks all 64 entries.
// Reset frees all entries and clears the dirty and accessed marks and the hand at once; the tag RAM is not reset.
// One beat waits in the output register while the next item is taken and worked on.
`default_nettype none

module sector_cache_clock_controller_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [scc_pkg::KIND_W-1:0]         kind,
	input  logic [scc_pkg::SECTOR_PORT_W-1:0]  sector,
	input  logic [scc_pkg::IDX_W-1:0]          entry_index,
	input  logic                               keep_dirty,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               hit,
	output logic [scc_pkg::IDX_W-1:0]          entry,
	output logic                               fill_request,
	output logic                               writeback_request,
	output logic [scc_pkg::SECTOR_PORT_W-1:0]  writeback_sector,
	output logic                               zero_data,
	output logic                               last
);
	import scc_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	scc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.kind        (kind),
		.entry_index (entry_index),
		.stat        (stat),
		.in_stall    (in_stall),
		.cmd         (cmd)
	);

	scc_dpath u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.kind              (kind),
		.sector            (sector),
		.entry_index       (entry_index),
		.keep_dirty        (keep_dirty),
		.stat              (stat),
		.out_stall         (out_stall),
		.out_valid         (out_valid),
		.hit               (hit),
		.entry             (entry),
		.fill_request      (fill_request),
		.writeback_request (writeback_request),
		.writeback_sector  (writeback_sector),
		.zero_data         (zero_data),
		.last              (last)
	);

endmodule

`default_nettype wire

// File: hw/rtl/scc_tag_ram.sv
// Tag store: one bank per lane, all banks read at the same row, one lane written.
// Read data is registered. Depends on scc_pkg.
`default_nettype none

module scc_tag_ram (
	input  logic              clk,
	input  logic              we,
	input  scc_pkg::row_t     wr_row,
	input  scc_pkg::lane_t    wr_lane,
	input  scc_pkg::tag_t     wr_data,
	input  logic              rd_en,
	input  scc_pkg::row_t     rd_row,
	output scc_pkg::tag_row_t rd_data
);
	import scc_pkg::*;

	for (genvar l = 0; l < LANES; l++) begin : g_bank
		tag_t mem [ROWS];
		tag_t rd_q;

		always_ff @(posedge clk) begin
			if (we && wr_lane == lane_t'(l)) begin
				mem[wr_row] <= wr_data;
			end
			if (rd_en) begin
				rd_q <= mem[rd_row];
			end
		end

		assign rd_data[l] = rd_q;
	end

endmodule

`default_nettype wire

// File: hw/rtl/scc_dpath.sv
// Datapath: request registers, row-wise tag scan, entry marks, clock hand,
// flush pointer, pending flush beat and output register. Depends on scc_pkg, scc_tag_ram.
`default_nettype none

module scc_dpath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  scc_pkg::cmd_t                      cmd,
	input  logic [scc_pkg::KIND_W-1:0]         kind,
	input  logic [scc_pkg::SECTOR_PORT_W-1:0]  sector,
	input  logic [scc_pkg::IDX_W-1:0]          entry_index,
	input  logic                               keep_dirty,
	output scc_pkg::stat_t                     stat,
	input  logic                               out_stall,
	output logic                               out_valid,
	output logic                               hit,
	output logic [scc_pkg::IDX_W-1:0]          entry,
	output logic                               fill_request,
	output logic                               writeback_request,
	output logic [scc_pkg::SECTOR_PORT_W-1:0]  writeback_sector,
	output logic                               zero_data,
	output logic                               last
);
	import scc_pkg::*;

	logic [KIND_W-1:0] req_kind_q;
	tag_t              req_sector_q;
	idx_t              req_idx_q;
	logic              req_keep_q;

	row_t rptr_q;
	logic iss_done_q;
	logic cmp_vld_s1;
	row_t cmp_row_s1;
	logic done_q;
	logic hit_q;
	logic found_q;
	idx_t hit_entry_q;
	idx_t free_entry_q;

	idx_t sel_q;
	idx_t hand_q;
	idx_t fptr_q;

	logic [ENTRIES-1:0] free_q;
	logic [ENTRIES-1:0] dirty_q;
	logic [ENTRIES-1:0] acc_q;

	logic pend_vld_q;
	idx_t pend_entry_q;
	tag_t pend_sec_q;

	logic out_vld_q;
	res_t out_q;
	res_t beat;

	logic     issue;
	logic     rd_en;
	row_t     rd_row;
	tag_row_t rd_data;
	logic     we;
	logic [LANES-1:0] match_v;
	logic [LANES-1:0] free_v;
	tag_t     sel_tag;
	tag_t     req_tag;
	tag_t     f_tag;
	logic     out_free;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_kind_q   <= kind;
			req_sector_q <= sector[SECTOR_BITS-1:0];
			req_idx_q    <= entry_index;
			req_keep_q   <= keep_dirty;
		end
	end

	assign issue = cmd.scan_en && !iss_done_q;

	always_comb begin
		rd_en  = 1'b0;
		rd_row = '0;
		case (cmd.rd_sel)
			RD_SCAN: begin
				rd_en  = issue;
				rd_row = rptr_q;
			end
			RD_SEL: begin
				rd_en  = 1'b1;
				rd_row = row_of(sel_q);
			end
			RD_REQ: begin
				rd_en  = 1'b1;
				rd_row = row_of(req_idx_q);
			end
			RD_FPTR: begin
				rd_en  = 1'b1;
				rd_row = row_of(fptr_q);
			end
			default: begin
				rd_en  = 1'b0;
				rd_row = '0;
			end
		endcase
	end

	assign we = cmd.upd_lookup && !hit_q;

	scc_tag_ram u_tags (
		.clk     (clk),
		.we      (we),
		.wr_row  (row_of(sel_q)),
		.wr_lane (lane_of(sel_q)),
		.wr_data (req_sector_q),
		.rd_en   (rd_en),
		.rd_row  (rd_row),
		.rd_data (rd_data)
	);

	// Compare one row of eight tags against the requested sector.
	always_comb begin
		idx_t e;
		for (int l = 0; l < LANES; l++) begin
			e          = {cmp_row_s1, lane_t'(l)};
			match_v[l] = !free_q[e] && rd_data[l] == req_sector_q;
			free_v[l]  = free_q[e];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rptr_q       <= '0;
			iss_done_q   <= 1'b0;
			cmp_vld_s1   <= 1'b0;
			cmp_row_s1   <= '0;
			done_q       <= 1'b0;
			hit_q        <= 1'b0;
			found_q      <= 1'b0;
			hit_entry_q  <= '0;
			free_entry_q <= '0;
		end else if (cmd.scan_clr) begin
			rptr_q     <= '0;
			iss_done_q <= 1'b0;
			cmp_vld_s1 <= 1'b0;
			done_q     <= 1'b0;
			hit_q      <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			cmp_vld_s1 <= issue;
			if (issue) begin
				cmp_row_s1 <= rptr_q;
				rptr_q     <= rptr_q + row_t'(1);
				if (rptr_q == row_t'(ROWS - 1)) begin
					iss_done_q <= 1'b1;
				end
			end
			if (cmp_vld_s1 && !done_q) begin
				if (|match_v) begin
					hit_q       <= 1'b1;
					hit_entry_q <= {cmp_row_s1, first_lane(match_v)};
					done_q      <= 1'b1;
				end else begin
					if (!found_q && |free_v) begin
						found_q      <= 1'b1;
						free_entry_q <= {cmp_row_s1, first_lane(free_v)};
					end
					if (cmp_row_s1 == row_t'(ROWS - 1)) begin
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sel_scan) begin
			sel_q <= hit_q ? hit_entry_q : free_entry_q;
		end else if (cmd.sel_hand) begin
			sel_q <= hand_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hand_q <= '0;
			fptr_q <= '0;
		end else begin
			if (cmd.hand_step) begin
				hand_q <= (hand_q == idx_t'(ENTRIES - 1)) ? '0 : hand_q + idx_t'(1);
			end
			if (cmd.fptr_clr) begin
				fptr_q <= '0;
			end else if (cmd.fptr_inc) begin
				fptr_q <= fptr_q + idx_t'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q  <= '1;
			dirty_q <= '0;
			acc_q   <= '0;
		end else begin
			if (cmd.upd_lookup) begin
				if (!hit_q) begin
					free_q[sel_q] <= 1'b0;
					if (req_kind_q == KIND_READ) begin
						dirty_q[sel_q] <= 1'b0;
					end
				end
				if (req_kind_q != KIND_READ) begin
					dirty_q[sel_q] <= 1'b1;
				end
				acc_q[sel_q] <= 1'b1;
			end
			if (cmd.upd_release) begin
				free_q[req_idx_q]  <= 1'b1;
				dirty_q[req_idx_q] <= 1'b0;
				acc_q[req_idx_q]   <= 1'b0;
			end
			if (cmd.hand_step) begin
				acc_q[hand_q] <= 1'b0;
			end
			if (cmd.flush_take && !req_keep_q) begin
				dirty_q[fptr_q] <= 1'b0;
			end
		end
	end

	assign sel_tag = rd_data[lane_of(sel_q)];
	assign req_tag = rd_data[lane_of(req_idx_q)];
	assign f_tag   = rd_data[lane_of(fptr_q)];

	// A flush beat is held back until the next dirty entry or the end of the walk, so that the last one can be marked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
		end else if (cmd.flush_take) begin
			pend_vld_q <= 1'b1;
		end else if (cmd.push && cmd.beat == BEAT_FLUSH_END) begin
			pend_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.flush_take) begin
			pend_entry_q <= fptr_q;
			pend_sec_q   <= f_tag;
		end
	end

	always_comb begin
		beat = '0;
		case (cmd.beat)
			BEAT_LOOKUP: begin
				beat.hit   = hit_q;
				beat.entry = sel_q;
				beat.fill  = !hit_q;
				beat.wb    = !hit_q && !free_q[sel_q] && dirty_q[sel_q];
				beat.wbsec = beat.wb ? sel_tag : '0;
				beat.zero  = (req_kind_q == KIND_ZERO);
				beat.last  = 1'b1;
			end
			BEAT_RELEASE: begin
				beat.entry = req_idx_q;
				beat.wb    = !free_q[req_idx_q] && dirty_q[req_idx_q];
				beat.wbsec = beat.wb ? req_tag : '0;
				beat.last  = 1'b1;
			end
			BEAT_FLUSH_MID: begin
				beat.entry = pend_entry_q;
				beat.wb    = 1'b1;
				beat.wbsec = pend_sec_q;
			end
			BEAT_FLUSH_END: begin
				if (pend_vld_q) begin
					beat.entry = pend_entry_q;
					beat.wb    = 1'b1;
					beat.wbsec = pend_sec_q;
				end
				beat.last = 1'b1;
			end
			default: beat = '0;
		endcase
	end

	assign out_free = !out_vld_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.push) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_q <= beat;
		end
	end

	assign out_valid         = out_vld_q;
	assign hit               = out_q.hit;
	assign entry             = out_q.entry;
	assign fill_request      = out_q.fill;
	assign writeback_request = out_q.wb;
	assign writeback_sector  = SECTOR_PORT_W'(out_q.wbsec);
	assign zero_data         = out_q.zero;
	assign last              = out_q.last;

	assign stat.scan_done = done_q;
	assign stat.hit       = hit_q;
	assign stat.found     = found_q;
	assign stat.hand_acc  = acc_q[hand_q];
	assign stat.out_free  = out_free;
	assign stat.flush_sel = !free_q[fptr_q] && dirty_q[fptr_q];
	assign stat.flush_end = (fptr_q == idx_t'(ENTRIES - 1));
	assign stat.pend_vld  = pend_vld_q;

endmodule

`default_nettype wire

// File: hw/rtl/scc_ctrl.sv
// Controller state machine: sequences lookup scan, clock sweep, release and flush
// by driving datapath commands from datapath status. Depends on scc_pkg.
`default_nettype none

module scc_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [scc_pkg::KIND_W-1:0] kind,
	input  logic [scc_pkg::IDX_W-1:0]  entry_index,
	input  scc_pkg::stat_t             stat,
	output logic                       in_stall,
	output scc_pkg::cmd_t              cmd
);
	import scc_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE    = 10'b00_0000_0001,
		ST_LOOKUP  = 10'b00_0000_0010,
		ST_SWEEP   = 10'b00_0000_0100,
		ST_TAG_RD  = 10'b00_0000_1000,
		ST_LK_EMIT = 10'b00_0001_0000,
		ST_REL_RD  = 10'b00_0010_0000,
		ST_REL_OUT = 10'b00_0100_0000,
		ST_FL_RD   = 10'b00_1000_0000,
		ST_FL_CHK  = 10'b01_0000_0000,
		ST_FL_END  = 10'b10_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   idx_ok;

	assign idx_ok   = ({1'b0, entry_index} < (IDX_W + 1)'(ENTRIES));
	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load     = 1'b1;
					cmd.scan_clr = 1'b1;
					cmd.fptr_clr = 1'b1;
					case (kind_t'(kind))
						KIND_READ, KIND_WRITE, KIND_ZERO: state_d = ST_LOOKUP;
						KIND_RELEASE: begin
							if (idx_ok) begin
								state_d = ST_REL_RD;
							end
						end
						KIND_FLUSH: state_d = ST_FL_RD;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_LOOKUP: begin
				cmd.scan_en = 1'b1;
				cmd.rd_sel  = RD_SCAN;
				if (stat.scan_done) begin
					if (stat.hit) begin
						cmd.sel_scan = 1'b1;
						state_d      = ST_LK_EMIT;
					end else if (stat.found) begin
						cmd.sel_scan = 1'b1;
						state_d      = ST_TAG_RD;
					end else begin
						state_d = ST_SWEEP;
					end
				end
			end
			ST_SWEEP: begin
				// Second chance: clear the accessed mark and move on, or stop here.
				if (stat.hand_acc) begin
					cmd.hand_step = 1'b1;
				end else begin
					cmd.sel_hand = 1'b1;
					state_d      = ST_TAG_RD;
				end
			end
			ST_TAG_RD: begin
				cmd.rd_sel = RD_SEL;
				state_d    = ST_LK_EMIT;
			end
			ST_LK_EMIT: begin
				if (stat.out_free) begin
					cmd.push       = 1'b1;
					cmd.beat       = BEAT_LOOKUP;
					cmd.upd_lookup = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			ST_REL_RD: begin
				cmd.rd_sel = RD_REQ;
				state_d    = ST_REL_OUT;
			end
			ST_REL_OUT: begin
				if (stat.out_free) begin
					cmd.push        = 1'b1;
					cmd.beat        = BEAT_RELEASE;
					cmd.upd_release = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			ST_FL_RD: begin
				cmd.rd_sel = RD_FPTR;
				state_d    = ST_FL_CHK;
			end
			ST_FL_CHK: begin
				// A new dirty entry displaces the held beat, which needs a free output.
				if (!(stat.flush_sel && stat.pend_vld && !stat.out_free)) begin
					if (stat.flush_sel) begin
						cmd.flush_take = 1'b1;
						if (stat.pend_vld) begin
							cmd.push = 1'b1;
							cmd.beat = BEAT_FLUSH_MID;
						end
					end
					cmd.fptr_inc = 1'b1;
					state_d      = stat.flush_end ? ST_FL_END : ST_FL_RD;
				end
			end
			ST_FL_END: begin
				if (stat.out_free) begin
					cmd.push = 1'b1;
					cmd.beat = BEAT_FLUSH_END;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// File: hw/rtl/scc_checker.sv
// Port-level checker for the sector cache clock controller, bound to the top level.
// Depends on scc_pkg and sector_cache_clock_controller_unit.
`default_nettype none

module scc_props (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic [scc_pkg::KIND_W-1:0]         kind,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic                               hit,
	input logic [scc_pkg::IDX_W-1:0]          entry,
	input logic                               fill_request,
	input logic                               writeback_request,
	input logic [scc_pkg::SECTOR_PORT_W-1:0]  writeback_sector,
	input logic                               zero_data,
	input logic                               last
);
	import scc_pkg::*;

	// A stalled beat stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(entry) && $stable(writeback_sector)
			&& $stable(last))
		else $error("output beat changed while stalled");

	// A hit never asks for a fill.
	a_hit_no_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && fill_request))
		else $error("hit beat carries a fill request");

	// No writeback, no writeback sector.
	a_wbsec_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !writeback_request |-> writeback_sector == '0)
		else $error("writeback sector set without a writeback");

	// A zero fill gives a single, final beat.
	a_zero_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_data |-> last && !writeback_request || last)
		else $error("zero fill beat is not the last one");

	// Every read, write, zero fill or flush request keeps the block busy on the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (kind == KIND_READ || kind == KIND_WRITE
			|| kind == KIND_ZERO || kind == KIND_FLUSH) |=> in_stall)
		else $error("block took a request and stayed idle");

endmodule

bind sector_cache_clock_controller_unit scc_props u_scc_props (.*);

`default_nettype wire
